>>> hdl/debruijn_branch_code_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder: assertion macros
// Concurrent checks used by the decoder control module; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DEBRUIJN_BRANCH_CODE_DECODER_UNIT_MACROS_SVH
`define DEBRUIJN_BRANCH_CODE_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define DBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dbc: assertion failed");
// Next-cycle implication
`define DBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dbc: assertion failed");
`else
`define DBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DBC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder package
// Shared widths, codes, state encoding and the character-to-base mapping.
// ----------------------------------------------------------------------------
package dbc_pkg;

  // Default maximum k-mer length
  localparam int unsigned K_MAX_DEFAULT = 10;

  // Word field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned EDGE_W = 22;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BASE_W = 2;
  localparam int unsigned ADV_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned KLEN_W = 4;
  localparam int unsigned MASK_W = 4;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Register reset values
  localparam logic [KLEN_W-1:0] KMER_LEN_RST = 4'd10;
  localparam logic              KMER_FMT_RST = 1'b0;

  // Register indexes (address bit 2)
  localparam logic REG_KMER_LEN = 1'b0;
  localparam logic REG_KMER_FMT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_EDGE = 2'd0,
    OP_SEED      = 2'd1,
    OP_DECODE    = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_SUCC = 2'd1,
    ST_NO_CODE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [KLEN_W-1:0] eff_k;
    logic              kmer_format;
  } cfg_t;

  // Map an ASCII character to a 2-bit base; anything not ACGT becomes A
  function automatic logic [BASE_W-1:0] char_to_base(input logic [CHAR_W-1:0] c);
    logic [BASE_W-1:0] b;
    case (c)
      8'h43, 8'h63: b = 2'd1;
      8'h47, 8'h67: b = 2'd2;
      8'h54, 8'h74: b = 2'd3;
      default:      b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/dbc_if.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder channel interfaces
// Valid/ready channels for the command words and the result words.
// ----------------------------------------------------------------------------
interface dbc_in_if import dbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [EDGE_W-1:0] edge_req;
  logic [CHAR_W-1:0] symbol_char;
  logic              symbol_valid;

  modport source (output valid, operation, edge_req, symbol_char, symbol_valid,
                  input ready);
  modport sink   (input valid, operation, edge_req, symbol_char, symbol_valid,
                  output ready);
endinterface

interface dbc_out_if import dbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base_code;
  logic [ADV_W-1:0]  brc_advance;
  logic [STAT_W-1:0] status;

  modport source (output valid, base_code, brc_advance, status, input ready);
  modport sink   (input valid, base_code, brc_advance, status, output ready);
endinterface

>>> hdl/dbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder configuration registers
// APB-style register file for k and the k-mer format flag; derives clamped k.
// ----------------------------------------------------------------------------
module dbc_cfg_regs import dbc_pkg::*; #(
  parameter int unsigned K_MAX = K_MAX_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  localparam logic [KLEN_W:0] KMaxW = (KLEN_W+1)'(K_MAX);

  logic [KLEN_W-1:0] kmer_len_q, kmer_len_d;
  logic              kmer_fmt_q, kmer_fmt_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the write
  always_comb begin
    kmer_len_d = kmer_len_q;
    kmer_fmt_d = kmer_fmt_q;
    if (wr_en) begin
      case (paddr[2])
        REG_KMER_LEN: kmer_len_d = pwdata[KLEN_W-1:0];
        REG_KMER_FMT: kmer_fmt_d = pwdata[0];
        default:      kmer_len_d = kmer_len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= KMER_LEN_RST;
      kmer_fmt_q <= KMER_FMT_RST;
    end else begin
      kmer_len_q <= kmer_len_d;
      kmer_fmt_q <= kmer_fmt_d;
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_KMER_LEN: prdata = {{(CFG_DW-KLEN_W){1'b0}}, kmer_len_q};
      REG_KMER_FMT: prdata = {{(CFG_DW-1){1'b0}}, kmer_fmt_q};
      default:      prdata = '0;
    endcase
  end

  // Clamp k into 1..K_MAX
  always_comb begin
    if (kmer_len_q == '0) begin
      cfg_o.eff_k = KLEN_W'(1);
    end else if ({1'b0, kmer_len_q} > KMaxW) begin
      cfg_o.eff_k = KMaxW[KLEN_W-1:0];
    end else begin
      cfg_o.eff_k = kmer_len_q;
    end
    cfg_o.kmer_format = kmer_fmt_q;
  end

endmodule

>>> hdl/dbc_succ_mem.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder successor table
// Synchronous memory of 4-bit successor masks with separate read and write
// ports, and a clearing sweep after reset that writes every entry to zero.
// ----------------------------------------------------------------------------
module dbc_succ_mem import dbc_pkg::*; #(
  parameter int unsigned AW = 2 * K_MAX_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [MASK_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [MASK_W-1:0] wr_data_i,
  output logic              clr_busy_o
);

  localparam int unsigned Depth = 2 ** AW;

  logic [MASK_W-1:0] mem [Depth];
  logic [MASK_W-1:0] rd_data_q;
  logic              clr_q, clr_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;

  // Advance the clearing sweep, one entry a cycle
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == {AW{1'b1}}) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Write port: sweep first, then normal write-back
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_q;

endmodule

>>> hdl/dbc_ctrl.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder control and datapath
// Takes command words, reads the successor table, writes back loaded edges,
// resolves decode steps into result words and keeps the current k-mer.
// ----------------------------------------------------------------------------
`include "debruijn_branch_code_decoder_unit_macros.svh"

module dbc_ctrl import dbc_pkg::*; #(
  parameter int unsigned K_MAX = K_MAX_DEFAULT,
  parameter int unsigned AW    = 2 * K_MAX
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  dbc_in_if.sink            in_i,
  dbc_out_if.source         out_o,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [MASK_W-1:0] rd_data_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [MASK_W-1:0] wr_data_o,
  input  logic              clr_busy_i
);

  state_e            state_q, state_d;
  logic [AW-1:0]     kmer_q, kmer_d;
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] char_q;
  logic              sym_valid_q;
  logic [BASE_W-1:0] edge_low_q;
  logic [AW-1:0]     addr_q;

  logic              out_valid_q, out_valid_d;
  logic [BASE_W-1:0] base_q;
  logic [ADV_W-1:0]  adv_q;
  status_e           status_q;

  logic              in_acc;
  logic              needs_read;
  logic [AW+19:0]    edge_ext;
  logic [AW-1:0]     edge_idx;
  logic [AW-1:0]     kmask;
  logic              out_free;
  logic              result_load;
  logic [BASE_W-1:0] res_base;
  logic [ADV_W-1:0]  res_adv;
  status_e           res_status;
  logic [BASE_W-1:0] shift_base;
  logic              shift_en;
  logic [AW+1:0]     kmer_sh;

  assign in_acc     = in_i.valid & in_i.ready;
  assign needs_read = (in_i.operation == OP_LOAD_EDGE) || (in_i.operation == OP_DECODE);
  assign out_free   = !out_valid_q || out_o.ready;

  // Table index of an edge: drop the last base, fit to the table width
  assign edge_ext = {{AW{1'b0}}, in_i.edge_req[EDGE_W-1:2]};
  assign edge_idx = edge_ext[AW-1:0];

  // Keep 2k bits of the k-mer
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      kmask[i] = (6'(i) < {1'b0, cfg_i.eff_k, 1'b0});
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (!clr_busy_i) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && needs_read) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (op_q == OP_LOAD_EDGE) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready  = 1'b0;
    rd_en_o     = 1'b0;
    wr_en_o     = 1'b0;
    result_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        rd_en_o    = in_i.valid && needs_read;
      end
      S_LOOKUP: begin
        wr_en_o     = (op_q == OP_LOAD_EDGE);
        result_load = (op_q == OP_DECODE) && out_free;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  assign rd_addr_o = (in_i.operation == OP_LOAD_EDGE) ? edge_idx : kmer_q;
  assign wr_addr_o = addr_q;
  assign wr_data_o = rd_data_i | (MASK_W'(1) << edge_low_q);

  // Resolve a decode step from the looked-up mask
  always_comb begin
    res_base   = '0;
    res_adv    = '0;
    res_status = ST_OK;
    if (rd_data_i == '0) begin
      res_status = ST_NO_SUCC;
    end else if ($onehot(rd_data_i)) begin
      case (rd_data_i)
        4'b0010: res_base = 2'd1;
        4'b0100: res_base = 2'd2;
        4'b1000: res_base = 2'd3;
        default: res_base = 2'd0;
      endcase
    end else if (!sym_valid_q) begin
      res_status = ST_NO_CODE;
    end else begin
      res_base = char_to_base(char_q);
      res_adv  = cfg_i.kmer_format ? cfg_i.eff_k : ADV_W'(1);
    end
  end

  // Shift a base into the k-mer on a seed or a good decode step
  always_comb begin
    shift_en   = 1'b0;
    shift_base = res_base;
    if (in_acc && (in_i.operation == OP_SEED)) begin
      shift_en   = 1'b1;
      shift_base = char_to_base(in_i.symbol_char);
    end else if (result_load && (res_status == ST_OK)) begin
      shift_en = 1'b1;
    end
    kmer_sh = {kmer_q, shift_base};
    kmer_d  = shift_en ? (kmer_sh[AW-1:0] & kmask) : kmer_q;
  end

  // Hold the result word until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      kmer_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kmer_q      <= kmer_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= in_i.operation;
      char_q      <= in_i.symbol_char;
      sym_valid_q <= in_i.symbol_valid;
      edge_low_q  <= in_i.edge_req[1:0];
      addr_q      <= edge_idx;
    end
  end

  // Latch the result word
  always_ff @(posedge clk_i) begin
    if (result_load) begin
      base_q   <= res_base;
      adv_q    <= res_adv;
      status_q <= res_status;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.base_code   = base_q;
  assign out_o.brc_advance = adv_q;
  assign out_o.status      = status_q;

  // Checks
  `DBC_ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni, clr_busy_i, !in_i.ready)
  `DBC_ASSERT_NXT(a_read_then_lookup, clk_i, rst_ni, rd_en_o && in_i.ready, state_q == S_LOOKUP)
  `DBC_ASSERT_NXT(a_stalled_lookup_holds, clk_i, rst_ni,
                  state_q == S_LOOKUP && op_q == OP_DECODE && out_valid_q && !out_o.ready,
                  state_q == S_LOOKUP && !in_i.ready)

endmodule

>>> hdl/debruijn_branch_code_decoder_unit.sv
// ----------------------------------------------------------------------------
// De Bruijn branch-code decoder unit
// Decodes a branch-code stream against a de Bruijn successor table.
// ----------------------------------------------------------------------------
//  channel  dir  protocol     payload
//  in_i     in   valid/ready  operation, edge_req, symbol_char, symbol_valid
//  out_o    out  valid/ready  base_code, brc_advance, status
//  cfg      in   APB          kmer_len @0x0, kmer_format @0x4
//
//  A seed word is handled in the idle state; a load-edge or decode word moves
//  on to the lookup state, since the successor table read is registered ahead
//  of the write-back or the result. After reset a clearing pass zeroes all
//  4^K_MAX table entries (1048576 at K_MAX = 10), during which no word is
//  taken; register writes are. A decode word whose result finds the output
//  word still untaken waits in the lookup state until it is taken.
// ----------------------------------------------------------------------------
module debruijn_branch_code_decoder_unit import dbc_pkg::*; #(
  parameter int unsigned K_MAX = K_MAX_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dbc_in_if.sink            in_i,
  dbc_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = 2 * K_MAX;

  cfg_t              cfg;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [MASK_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [MASK_W-1:0] wr_data;
  logic              clr_busy;

  dbc_cfg_regs #(.K_MAX(K_MAX)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbc_succ_mem #(.AW(AW)) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .clr_busy_o (clr_busy)
  );

  dbc_ctrl #(.K_MAX(K_MAX), .AW(AW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_i       (in_i),
    .out_o      (out_o),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .clr_busy_i (clr_busy)
  );

endmodule
